// ----- src/empc_pkg.sv -----
// Shared types, constants and helper functions of the encoder mode panel controller.
package empc_pkg;

    localparam int SETTING_W = 6;
    localparam int MODE_W    = 2;
    localparam int LEVEL_W   = 8;
    localparam int CHAR_W    = 8;
    localparam int ZONE_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [SETTING_W-1:0] SETTING_MAX = 6'd39;

    localparam logic [MODE_W-1:0] MODE_ZERO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TWO  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MODE_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MODE_ONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MODE_TWO  = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_MODE_ZERO_RST = 8'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MODE_ONE_RST  = 8'd50;
    localparam logic [LEVEL_W-1:0] LEVEL_MODE_TWO_RST  = 8'd250;

    localparam logic [ZONE_W-1:0] ZONE_AUTO = 4'd10;

    localparam logic [CHAR_W-1:0] CHAR_P    = 8'h50;
    localparam logic [CHAR_W-1:0] CHAR_R    = 8'h52;
    localparam logic [CHAR_W-1:0] CHAR_T    = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

    typedef struct packed {
        logic mode_pin;
        logic push_pin;
        logic enc_data_pin;
        logic enc_clock_pin;
    } pins_t;

    typedef struct packed {
        logic [SETTING_W-1:0] setting_now;
        logic [MODE_W-1:0]    mode_now;
        logic [CHAR_W-1:0]    cmd_digit;
        logic [CHAR_W-1:0]    cmd_prefix;
        logic [LEVEL_W-1:0]   bright_level;
        logic [7:0]           segments;
    } result_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_two;
        logic [LEVEL_W-1:0] level_one;
        logic [LEVEL_W-1:0] level_zero;
    } levels_t;

    function automatic logic [ZONE_W-1:0] zone_of(input logic [MODE_W-1:0] mode,
                                                  input logic [SETTING_W-1:0] setting);
        logic [ZONE_W-1:0] zone;
        zone = ZONE_AUTO;
        case (mode)
            MODE_ZERO:
            begin
                if (setting < 6'd10)      zone = ZONE_AUTO;
                else if (setting < 6'd20) zone = 4'd0;
                else if (setting < 6'd30) zone = 4'd1;
                else                      zone = 4'd2;
            end
            MODE_ONE:
            begin
                if (setting < 6'd13)      zone = ZONE_AUTO;
                else if (setting < 6'd26) zone = 4'd0;
                else                      zone = 4'd1;
            end
            default:
            begin
                if (setting < 6'd32) zone = 4'd1 + {1'b0, setting[4:2]};
                else                 zone = 4'd9;
            end
        endcase
        return zone;
    endfunction

    function automatic logic [7:0] seg_of(input logic [ZONE_W-1:0] zone);
        logic [7:0] seg;
        case (zone)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h27;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h77;
        endcase
        return seg;
    endfunction

    function automatic logic [CHAR_W-1:0] prefix_of(input logic [MODE_W-1:0] mode);
        logic [CHAR_W-1:0] ch;
        case (mode)
            MODE_ZERO: ch = CHAR_P;
            MODE_ONE:  ch = CHAR_R;
            default:   ch = CHAR_T;
        endcase
        return ch;
    endfunction

endpackage

// ----- src/encoder_mode_panel_controller.sv -----
// Top level of the encoder mode panel controller: stream ports, level registers, stages.
// A sample that transfers in is held in the input register; when it fires, its result loads
// the result register, from which it transfers out.
// Throughput: one sample per cycle; a sample moves from the input register to the
// result register whenever the result register is empty or being read in that cycle.
// Reset clears both stage valid bits, mode, setting, the stored clock pin and first-sample flag,
// sets the stored push and mode pins high, and loads the three level registers with 0, 50 and 250.
module encoder_mode_panel_controller
    import empc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [0] enc_clock_pin, [1] enc_data_pin, [2] push_pin, [3] mode_pin, [7:4] zero
    input  logic [7:0]           s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] segments, [15:8] bright_level, [23:16] cmd_prefix, [31:24] cmd_digit,
    // [33:32] mode_now, [39:34] setting_now
    output logic [39:0]          m_axis_tdata,
    // [0] cmd_valid
    output logic                 m_axis_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data
);

    pins_t   s_pins;
    pins_t   pins;
    logic    pins_valid;
    logic    can_load;
    logic    fire;
    result_t result;
    result_t m_result;
    logic    cmd_valid;
    levels_t levels_reg;

    assign s_pins.enc_clock_pin = s_axis_tdata[0];
    assign s_pins.enc_data_pin  = s_axis_tdata[1];
    assign s_pins.push_pin      = s_axis_tdata[2];
    assign s_pins.mode_pin      = s_axis_tdata[3];

    assign fire      = pins_valid && can_load;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg.level_zero <= LEVEL_MODE_ZERO_RST;
            levels_reg.level_one  <= LEVEL_MODE_ONE_RST;
            levels_reg.level_two  <= LEVEL_MODE_TWO_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LEVEL_MODE_ZERO: levels_reg.level_zero <= cfg_data;
                REG_LEVEL_MODE_ONE:  levels_reg.level_one  <= cfg_data;
                REG_LEVEL_MODE_TWO:  levels_reg.level_two  <= cfg_data;
                default:             ;
            endcase
        end
    end

    empc_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_pins     (s_pins),
        .advance    (can_load),
        .pins_valid (pins_valid),
        .pins       (pins)
    );

    empc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .pins      (pins),
        .levels    (levels_reg),
        .result    (result),
        .cmd_valid (cmd_valid)
    );

    empc_output_stage u_output
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .result      (result),
        .cmd_valid   (cmd_valid),
        .can_load    (can_load),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_result    (m_result),
        .m_cmd_valid (m_axis_tuser)
    );

    assign m_axis_tdata = m_result;

endmodule

// ----- src/empc_input_stage.sv -----
// Input register that holds one sampled pin set until the core consumes it.
module empc_input_stage
    import empc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_valid,
    output logic  s_ready,
    input  pins_t s_pins,
    input  logic  advance,
    output logic  pins_valid,
    output pins_t pins
);

    logic  valid_reg;
    logic  valid_next;
    pins_t pins_reg;

    // The slot frees up in the same cycle that the core consumes its content.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            pins_reg <= s_pins;
        end
    end

    assign pins_valid = valid_reg;
    assign pins       = pins_reg;

endmodule

// ----- src/empc_core.sv -----
// Panel state (pin history, mode, setting) and the per-sample update logic.
module empc_core
    import empc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  pins_t   pins,
    input  levels_t levels,
    output result_t result,
    output logic    cmd_valid
);

    logic                 last_clock_reg;
    logic                 first_seen_reg;
    logic                 last_push_reg;
    logic                 last_mode_pin_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [SETTING_W-1:0] setting_reg;

    logic [MODE_W-1:0]    mode_next;
    logic [SETTING_W-1:0] setting_mid;
    logic [SETTING_W-1:0] setting_next;
    logic                 push_rise;
    logic                 mode_rise;
    logic                 clock_moved;
    logic [ZONE_W-1:0]    cmd_zone;

    assign push_rise   = !last_push_reg && pins.push_pin;
    assign mode_rise   = !last_mode_pin_reg && pins.mode_pin;
    assign clock_moved = first_seen_reg && (pins.enc_clock_pin != last_clock_reg);
    assign cmd_zone    = zone_of(mode_reg, setting_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        setting_mid = setting_reg;
        if (mode_rise)
        begin
            mode_next   = (mode_reg == MODE_TWO) ? MODE_ZERO : mode_reg + 2'd1;
            setting_mid = '0;
        end

        // Direction comes from the data pin relative to the new clock level.
        setting_next = setting_mid;
        if (clock_moved)
        begin
            if (pins.enc_data_pin != pins.enc_clock_pin)
            begin
                if (setting_mid < SETTING_MAX) setting_next = setting_mid + 6'd1;
            end
            else
            begin
                if (setting_mid != '0) setting_next = setting_mid - 6'd1;
            end
        end
    end

    always_comb
    begin
        result.segments    = seg_of(zone_of(mode_next, setting_next));
        case (mode_next)
            MODE_ZERO: result.bright_level = levels.level_zero;
            MODE_ONE:  result.bright_level = levels.level_one;
            default:   result.bright_level = levels.level_two;
        endcase
        result.cmd_prefix  = push_rise ? prefix_of(mode_reg) : '0;
        result.cmd_digit   = '0;
        if (push_rise)
        begin
            result.cmd_digit = (cmd_zone == ZONE_AUTO) ? CHAR_A
                                                        : CHAR_ZERO + {4'd0, cmd_zone};
        end
        result.mode_now    = mode_next;
        result.setting_now = setting_next;
    end

    assign cmd_valid = push_rise;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_clock_reg    <= 1'b0;
            first_seen_reg    <= 1'b0;
            last_push_reg     <= 1'b1;
            last_mode_pin_reg <= 1'b1;
            mode_reg          <= MODE_ZERO;
            setting_reg       <= '0;
        end
        else if (fire)
        begin
            last_clock_reg    <= pins.enc_clock_pin;
            first_seen_reg    <= 1'b1;
            last_push_reg     <= pins.push_pin;
            last_mode_pin_reg <= pins.mode_pin;
            mode_reg          <= mode_next;
            setting_reg       <= setting_next;
        end
    end

endmodule

// ----- src/empc_output_stage.sv -----
// Result register that holds one finished result until the downstream transfer.
module empc_output_stage
    import empc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    input  logic    cmd_valid,
    output logic    can_load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result,
    output logic    m_cmd_valid
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    logic    cmd_valid_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg    <= result;
            cmd_valid_reg <= cmd_valid;
        end
    end

    assign m_valid     = valid_reg;
    assign m_result    = result_reg;
    assign m_cmd_valid = cmd_valid_reg;

endmodule

// ----- src/empc_checker.sv -----
// Port-level checker for the encoder mode panel controller and its bind.
module empc_checker
    import empc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A stalled result transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3 && m_axis_tdata[39:34] <= SETTING_MAX)
    else $error("mode or setting out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[31:16] == 16'd0)
    else $error("command characters present without a command");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[23:16] == CHAR_P || m_axis_tdata[23:16] == CHAR_R ||
             m_axis_tdata[23:16] == CHAR_T))
    else $error("command prefix is not a mode letter");

endmodule

bind encoder_mode_panel_controller empc_checker u_empc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
